// ===== hdl/pht_pkg.sv =====
// Package for the pose to homogeneous transform block.
// Holds CORDIC constants and fixed-point widths; no dependencies.
`default_nettype none
package pht_pkg;
    localparam int TRIG_FRAC    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 33;   // CORDIC x/y/z width
    localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;

    function automatic logic signed [CW-1:0] atan_turn(input int i);
        logic signed [CW-1:0] t;
        case (i)
            0: t = 33'sd536870912;   1: t = 33'sd316933406;   2: t = 33'sd167458907;
            3: t = 33'sd85004756;    4: t = 33'sd42667331;    5: t = 33'sd21354465;
            6: t = 33'sd10679838;    7: t = 33'sd5340245;     8: t = 33'sd2670163;
            9: t = 33'sd1335087;    10: t = 33'sd667544;     11: t = 33'sd333772;
            12: t = 33'sd166886;    13: t = 33'sd83443;      14: t = 33'sd41722;
            15: t = 33'sd20861;     16: t = 33'sd10430;      17: t = 33'sd5215;
            18: t = 33'sd2608;      19: t = 33'sd1304;       20: t = 33'sd652;
            21: t = 33'sd326;       22: t = 33'sd163;        23: t = 33'sd81;
            24: t = 33'sd41;        25: t = 33'sd20;         26: t = 33'sd10;
            27: t = 33'sd5;         28: t = 33'sd3;          29: t = 33'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/pose_to_homogeneous_transform.sv =====
// Pose to homogeneous transform: three pipelined CORDIC sin/cos units,
// multiply stages and rounding/saturation. Depends on pht_pkg.
//
// Usage: a pose request enters on s_axis (tdata fields from lowest bit:
// pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle). The result leaves
// on m_axis (tdata fields from lowest bit: m00, m01, m02, m10, m11, m12, m20,
// m21, m22, tr_x, tr_y, tr_z).
// Throughput: one pose per cycle unless m_axis stalls; the pipeline depth
// is set by the 30 CORDIC rotation stages, one per register stage, and the
// two multiply levels.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is
// not reset. When the receiver stalls, full stages from the output back to the
// first gap hold; an empty stage takes new data, so bubbles are squeezed out.
`default_nettype none
module pose_to_homogeneous_transform
    import pht_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14,
    parameter int POS_BITS       = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle (low first)
    input  wire logic [((3*POS_BITS+3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, tr_x, tr_y, tr_z (low first)
    output logic [((9*(COEF_FRAC_BITS+2)+3*POS_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int CB   = COEF_FRAC_BITS + 2;
    localparam int NS   = CORDIC_STEPS + 6;          // stage count incl. output
    localparam int PW   = 3 * POS_BITS;
    localparam int PROD = 2 * CW;
    localparam int OUTW = ((9*CB + PW + 7) / 8) * 8;
    localparam int SH   = 2 * TRIG_FRAC - COEF_FRAC_BITS;
    localparam logic signed [PROD+1:0] LIM = (PROD+2)'(1) <<< COEF_FRAC_BITS;

    // Stall control: stage k advances when it is empty or the next moves.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;
    always_comb begin
        adv[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < NS; k++) if (adv[k]) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Position travels alongside.
    logic [PW-1:0] pos_reg [NS];
    always_ff @(posedge aclk) begin
        if (adv[0]) pos_reg[0] <= s_axis_tdata[PW-1:0];
        for (int k = 1; k < NS; k++) if (adv[k]) pos_reg[k] <= pos_reg[k-1];
    end

    // CORDIC: stage 0 loads, stages 1..CORDIC_STEPS rotate. Lane a = roll,pitch,yaw.
    logic signed [CW-1:0] x_reg [3][CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [3][CORDIC_STEPS+1];
    logic signed [CW-1:0] z_reg [3][CORDIC_STEPS+1];
    logic [1:0]           q_reg [3][CORDIC_STEPS+1];

    for (genvar a = 0; a < 3; a++) begin : g_lane
        logic [ANGLE_BITS-1:0] ang;
        logic [31:0]           ph;
        assign ang = s_axis_tdata[PW + a*ANGLE_BITS +: ANGLE_BITS];
        assign ph  = {ang, {(32-ANGLE_BITS){1'b0}}};
        always_ff @(posedge aclk) begin
            if (adv[0]) begin
                x_reg[a][0] <= CORDIC_START;
                y_reg[a][0] <= '0;
                z_reg[a][0] <= CW'({1'b0, ph[29:0]});
                q_reg[a][0] <= ph[31:30];
            end
        end
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            logic signed [CW-1:0] dx, dy;
            assign dx = y_reg[a][i] >>> i;
            assign dy = x_reg[a][i] >>> i;
            always_ff @(posedge aclk) begin
                if (adv[i+1]) begin
                    q_reg[a][i+1] <= q_reg[a][i];
                    if (!z_reg[a][i][CW-1]) begin
                        x_reg[a][i+1] <= x_reg[a][i] - dx;
                        y_reg[a][i+1] <= y_reg[a][i] + dy;
                        z_reg[a][i+1] <= z_reg[a][i] - atan_turn(i);
                    end else begin
                        x_reg[a][i+1] <= x_reg[a][i] + dx;
                        y_reg[a][i+1] <= y_reg[a][i] - dy;
                        z_reg[a][i+1] <= z_reg[a][i] + atan_turn(i);
                    end
                end
            end
        end
    end

    // Quadrant fold, registered (stage CORDIC_STEPS+1).
    localparam int SQ = CORDIC_STEPS + 1;
    logic signed [CW-1:0] sn_reg [3];
    logic signed [CW-1:0] cs_reg [3];
    always_ff @(posedge aclk) begin
        if (adv[SQ]) begin
            for (int a = 0; a < 3; a++) begin
                case (q_reg[a][CORDIC_STEPS])
                    2'd1: begin
                        cs_reg[a] <= -y_reg[a][CORDIC_STEPS];
                        sn_reg[a] <= x_reg[a][CORDIC_STEPS];
                    end
                    2'd2: begin
                        cs_reg[a] <= -x_reg[a][CORDIC_STEPS];
                        sn_reg[a] <= -y_reg[a][CORDIC_STEPS];
                    end
                    2'd3: begin
                        cs_reg[a] <= y_reg[a][CORDIC_STEPS];
                        sn_reg[a] <= -x_reg[a][CORDIC_STEPS];
                    end
                    default: begin
                        cs_reg[a] <= x_reg[a][CORDIC_STEPS];
                        sn_reg[a] <= y_reg[a][CORDIC_STEPS];
                    end
                endcase
            end
        end
    end

    // Stage SQ+1: sp*sr, sp*cr products; pass trig.
    logic signed [PROD-1:0] spsr_p_reg, spcr_p_reg;
    logic signed [CW-1:0]   t_reg [6];   // sr cr sp cp sy cy
    always_ff @(posedge aclk) begin
        if (adv[SQ+1]) begin
            spsr_p_reg <= sn_reg[1] * sn_reg[0];
            spcr_p_reg <= sn_reg[1] * cs_reg[0];
            for (int a = 0; a < 3; a++) begin
                t_reg[2*a]   <= sn_reg[a];
                t_reg[2*a+1] <= cs_reg[a];
            end
        end
    end

    // Stage SQ+2: round products to Q.30.
    logic signed [CW-1:0] spsr_reg, spcr_reg;
    logic signed [CW-1:0] u_reg [6];
    logic signed [PROD-1:0] rnd_a, rnd_b;
    assign rnd_a = (spsr_p_reg + (PROD'(1) <<< (TRIG_FRAC-1))) >>> TRIG_FRAC;
    assign rnd_b = (spcr_p_reg + (PROD'(1) <<< (TRIG_FRAC-1))) >>> TRIG_FRAC;
    always_ff @(posedge aclk) begin
        if (adv[SQ+2]) begin
            spsr_reg <= rnd_a[CW-1:0];
            spcr_reg <= rnd_b[CW-1:0];
            u_reg    <= t_reg;
        end
    end

    // Stage SQ+3: all Q.60 products.
    logic signed [PROD-1:0] p_reg [14];
    always_ff @(posedge aclk) begin
        if (adv[SQ+3]) begin
            p_reg[0]  <= u_reg[5] * u_reg[3];   // cy*cp
            p_reg[1]  <= u_reg[5] * spsr_reg;
            p_reg[2]  <= u_reg[4] * u_reg[1];   // sy*cr
            p_reg[3]  <= u_reg[5] * spcr_reg;
            p_reg[4]  <= u_reg[4] * u_reg[0];   // sy*sr
            p_reg[5]  <= u_reg[4] * u_reg[3];   // sy*cp
            p_reg[6]  <= u_reg[4] * spsr_reg;
            p_reg[7]  <= u_reg[5] * u_reg[1];   // cy*cr
            p_reg[8]  <= u_reg[4] * spcr_reg;
            p_reg[9]  <= u_reg[5] * u_reg[0];   // cy*sr
            p_reg[10] <= -(PROD'(u_reg[2]) <<< TRIG_FRAC);
            p_reg[11] <= u_reg[3] * u_reg[0];   // cp*sr
            p_reg[12] <= u_reg[3] * u_reg[1];   // cp*cr
            p_reg[13] <= '0;
        end
    end

    function automatic logic [CB-1:0] to_coef(input logic signed [PROD+1:0] v);
        logic signed [PROD+1:0] r;
        r = (v + ((PROD+2)'(1) <<< (SH-1))) >>> SH;
        if (r > LIM) r = LIM;
        if (r < -LIM) r = -LIM;
        return r[CB-1:0];
    endfunction

    // Stage SQ+4 (output): sums, rounding, saturation.
    logic signed [PROD+1:0] e [9];
    always_comb begin
        e[0] = (PROD+2)'(p_reg[0]);
        e[1] = (PROD+2)'(p_reg[1]) - (PROD+2)'(p_reg[2]);
        e[2] = (PROD+2)'(p_reg[3]) + (PROD+2)'(p_reg[4]);
        e[3] = (PROD+2)'(p_reg[5]);
        e[4] = (PROD+2)'(p_reg[6]) + (PROD+2)'(p_reg[7]);
        e[5] = (PROD+2)'(p_reg[8]) - (PROD+2)'(p_reg[9]);
        e[6] = (PROD+2)'(p_reg[10]) + (PROD+2)'(p_reg[13]);
        e[7] = (PROD+2)'(p_reg[11]);
        e[8] = (PROD+2)'(p_reg[12]);
    end

    logic [OUTW-1:0] out_next;
    always_comb begin
        out_next = '0;
        for (int j = 0; j < 9; j++) out_next[j*CB +: CB] = to_coef(e[j]);
        out_next[9*CB +: PW] = pos_reg[NS-2];
    end

    logic [OUTW-1:0] out_reg;
    always_ff @(posedge aclk) begin
        if (adv[NS-1]) begin
            out_reg <= out_next;
        end
    end
    assign m_axis_tdata = out_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $signed(m_axis_tdata[6*CB +: CB]) <= $signed(LIM[CB-1:0])
                       || m_axis_tdata[6*CB +: CB] == LIM[CB-1:0])
        else $error("coefficient out of range");
endmodule
`default_nettype wire
